>>> hdl/button_debounce_click_long_press_top_assert.svh
// Assertion macros for the button debounce block.
// Each expands to one labeled concurrent assertion on i_clk.
`ifndef BUTTON_DEBOUNCE_CLICK_LONG_PRESS_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_CLICK_LONG_PRESS_TOP_ASSERT_SVH

// Implication in the same cycle, off while reset is low
`define BDLP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bdlp assertion failed");

// Implication in the next cycle, off while reset is low
`define BDLP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bdlp assertion failed");

// Condition that must hold in the cycle after reset is seen low
`define BDLP_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("bdlp reset assertion failed");

`endif

>>> hdl/bdlp_pkg.sv
`default_nettype none

package bdlp_pkg;

    // Number of buttons tracked; the button field is one bit wide
    localparam int NUM_BUTTONS = 2;
    localparam int ADDR_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_DEBOUNCE   = 2'd0;
    localparam t_cfg_index CFG_LONG_PRESS = 2'd1;

    // Register reset values
    localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [15:0] LONG_PRESS_RST = 16'd800;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic        button;
        logic        pressed;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic button_out;
        logic debounced;
        logic single_click;
        logic long_press;
    } t_out_item;

    // Per-button state entry
    typedef struct packed {
        logic        level;
        logic        armed;
        logic [31:0] change_start;
        logic [31:0] press_start;
        logic        long_fired;
    } t_entry;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
    } t_cfg;

endpackage

`default_nettype wire

>>> hdl/bdlp_state_ram.sv
`default_nettype none

module bdlp_state_ram (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_rd_en,
    input  wire  bdlp_pkg::t_addr  i_rd_addr,
    output bdlp_pkg::t_entry      o_rd_data,
    input  wire                   i_wr_en,
    input  wire  bdlp_pkg::t_addr  i_wr_addr,
    input  bdlp_pkg::t_entry      i_wr_data
);
    import bdlp_pkg::*;

    t_entry                 r_mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_vld;
    t_entry                 r_rd_data;

    // Entry valid bits: an unwritten entry reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, write-first on a same-edge hit
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else if (r_vld[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hdl/bdlp_update.sv
`default_nettype none

module bdlp_update (
    input  bdlp_pkg::t_cfg       i_cfg,
    input  bdlp_pkg::t_in_item   i_item,
    input  bdlp_pkg::t_entry     i_entry,
    output bdlp_pkg::t_entry     o_entry,
    output logic                 o_wr_en,
    output bdlp_pkg::t_out_item  o_item
);
    import bdlp_pkg::*;

    logic        btn_ok;
    logic [31:0] start;
    logic        deb_done;
    logic        click;
    logic        lp;
    t_entry      n_entry;

    assign btn_ok = (int'(i_item.button) < NUM_BUTTONS);

    // Debounce and press tracking
    always_comb begin
        n_entry  = i_entry;
        click    = 1'b0;
        lp       = 1'b0;
        start    = i_entry.armed ? i_entry.change_start : i_item.now_ms;
        deb_done = (i_item.now_ms - start) >= 32'(i_cfg.debounce_ms);
        if (i_item.pressed != i_entry.level) begin
            n_entry.armed        = 1'b1;
            n_entry.change_start = start;
            if (deb_done) begin
                n_entry.level = i_item.pressed;
                n_entry.armed = 1'b0;
                if (i_item.pressed) begin
                    n_entry.press_start = i_item.now_ms;
                    n_entry.long_fired  = 1'b0;
                end else if (!i_entry.long_fired) begin
                    click = 1'b1;
                end
            end
        end else begin
            n_entry.armed = 1'b0;
        end

        // Long press fires once per press, after any accepted press
        if (n_entry.level && !n_entry.long_fired &&
            ((i_item.now_ms - n_entry.press_start) >= 32'(i_cfg.long_press_ms))) begin
            n_entry.long_fired = 1'b1;
            lp                 = 1'b1;
        end
    end

    assign o_entry             = n_entry;
    assign o_wr_en             = btn_ok;
    assign o_item.button_out   = i_item.button;
    assign o_item.debounced    = btn_ok & n_entry.level;
    assign o_item.single_click = btn_ok & click;
    assign o_item.long_press   = btn_ok & lp;

endmodule

`default_nettype wire

>>> hdl/button_debounce_click_long_press_top.sv
// Debounced pushbutton click and long-press detector. Each input beat is
// one poll sample (button, raw level, ms timestamp) and gives exactly one
// output beat with the debounced level and the click / long-press flags.
// Per-button state lives in a small RAM with a registered read; a sample
// reads its entry on acceptance, is updated in the update stage and is
// written back as that stage advances, with same-edge write data forwarded
// into the read so that samples of one button may follow back to back.
// Throughput is one sample per cycle while the result channel does not
// stall; each sample passes the RAM read, then the output register. State
// resets to released without a clearing pass. Registers: index 0 debounce_ms
// (reset 50), index 1 long_press_ms (reset 800); write them only while idle.
`default_nettype none

module button_debounce_click_long_press_top (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // sample channel
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  bdlp_pkg::t_in_item        i_in_item,
    // result channel
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output bdlp_pkg::t_out_item       o_out_item,
    // configuration channel
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire  bdlp_pkg::t_cfg_index i_cfg_index,
    input  wire  [15:0]               i_cfg_data
);
    import bdlp_pkg::*;

    t_cfg      r_cfg;
    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      in_acc;
    logic      s1_adv;
    t_entry    rd_entry;
    t_entry    upd_entry;
    logic      upd_wr;
    t_out_item upd_item;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_RST;
            r_cfg.long_press_ms <= LONG_PRESS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:   r_cfg.debounce_ms   <= i_cfg_data;
                CFG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: update stage moves whenever the output register frees up
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Update stage holds the sample while its entry is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc || (r_s1_valid && !s1_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in_item;
        end
    end

    bdlp_state_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (ADDR_W'(i_in_item.button)),
        .o_rd_data (rd_entry),
        .i_wr_en   (s1_adv && upd_wr),
        .i_wr_addr (ADDR_W'(r_s1_item.button)),
        .i_wr_data (upd_entry)
    );

    bdlp_update u_upd (
        .i_cfg   (r_cfg),
        .i_item  (r_s1_item),
        .i_entry (rd_entry),
        .o_entry (upd_entry),
        .o_wr_en (upd_wr),
        .o_item  (upd_item)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_item <= upd_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

>>> hdl/bdlp_checker.sv
`default_nettype none
`include "button_debounce_click_long_press_top_assert.svh"

module bdlp_checker (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        o_out_valid,
    input  wire                        i_out_stall,
    input  bdlp_pkg::t_out_item        o_out_item
);
    import bdlp_pkg::*;

    // No result beat right after reset
    `BDLP_ASSERT_RST(a_rst_quiet, !o_out_valid)

    // A stalled result beat stays and keeps its payload
    `BDLP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

    // A click is a release, so the level after it is released
    `BDLP_ASSERT_IMPL(a_click_rel, o_out_valid && o_out_item.single_click, !o_out_item.debounced)

    // A long press only while held
    `BDLP_ASSERT_IMPL(a_long_held, o_out_valid && o_out_item.long_press, o_out_item.debounced)

endmodule

bind button_debounce_click_long_press_top bdlp_checker u_bdlp_checker (.*);

`default_nettype wire
